// ===== hdl/sli_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted list package
// Shared types and codes for the sorted list insert and remove unit.
// ----------------------------------------------------------------------------
package sli_pkg;

    // Field widths of the stream payloads.
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 5;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    // Command carried in the input tuser bit.
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_REM_RD,
        S_REM_CMP,
        S_FINISH
    } seq_state_t;

endpackage

// ===== hdl/sli_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module sli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/sorted_list_insert_remove_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted list insert and remove unit
// Keeps up to DEPTH signed 32-bit values in ascending order in a RAM. Each
// input transfer carries a command in tuser (insert or remove) and a value in
// tdata, and produces one result transfer with a status, the entry count and
// the smallest held entry (zero when empty). An insert lands after all equal
// entries; a remove deletes the first equal entry. One command is worked at a
// time and the input is not ready meanwhile. The RAM has one read and one
// write port with a registered read, so the sequencer visits each entry in
// a read state and then a compare state. An insert into a full list goes
// straight to the finish state. A result waiting at the output stalls only
// the completion of the next command.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_unit #(
    parameter int DEPTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input channel.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sli_pkg::S_DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic                         s_tuser,   // [0] cmd
    // Result channel.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sli_pkg::M_DATA_W-1:0] m_tdata    // [1:0] status, [6:2] entry_total,
                                                    // [38:7] smallest, [39] zero
);

    import sli_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Sequencer and datapath registers.
    seq_state_t                 state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic                       found_reg, found_next;
    logic signed [VALUE_W-1:0]  value_reg, value_next;
    status_t                    status_reg, status_next;
    logic signed [VALUE_W-1:0]  head_reg;
    logic                       m_tvalid_reg;
    logic [M_DATA_W-1:0]        m_tdata_reg;

    // RAM port signals.
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    logic [VALUE_W-1:0]         ram_wdata;
    logic [IDX_W-1:0]           ram_raddr;
    logic [VALUE_W-1:0]         ram_rdata;

    logic [CNT_W-1:0]           idx_dec;
    logic                       in_xfer;
    logic                       out_load;
    logic                       rd_greater;
    logic                       rd_equal;
    logic signed [VALUE_W-1:0]  smallest;

    assign idx_dec    = idx_reg - CNT_W'(1);
    assign in_xfer    = s_tvalid && s_tready;
    assign rd_greater = $signed(ram_rdata) > value_reg;
    assign rd_equal   = $signed(ram_rdata) == value_reg;

    sli_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    if (cmd_t'(s_tuser) == CMD_REMOVE) begin
                        state_next = S_REM_RD;
                    end else if (count_reg == CNT_W'(DEPTH)) begin
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_INS_RD;
                    end
                end
            end
            S_INS_RD: begin
                if (idx_reg == '0) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (rd_greater) begin
                    state_next = S_INS_RD;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_REM_RD: begin
                if (idx_reg == count_reg) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = S_REM_CMP;
                end
            end
            S_REM_CMP: state_next = S_REM_RD;
            S_FINISH: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and RAM controls.
    always_comb begin
        s_tready  = 1'b0;
        out_load  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = idx_reg[IDX_W-1:0];
        ram_wdata = value_reg;
        ram_raddr = idx_reg[IDX_W-1:0];
        case (state_reg)
            S_IDLE: s_tready = 1'b1;
            S_INS_RD: begin
                // Read the entry just below the hole; at the bottom, fill it.
                ram_raddr = idx_dec[IDX_W-1:0];
                ram_we    = (idx_reg == '0);
            end
            S_INS_CMP: begin
                // Larger entries move up one place; otherwise the value lands.
                ram_we = 1'b1;
                if (rd_greater) begin
                    ram_wdata = ram_rdata;
                end
            end
            S_REM_CMP: begin
                // After the match, every entry moves down one place.
                ram_we    = found_reg;
                ram_waddr = idx_dec[IDX_W-1:0];
                ram_wdata = ram_rdata;
            end
            S_FINISH: out_load = !m_tvalid_reg || m_tready;
            default: s_tready = 1'b0;
        endcase
    end

    // Datapath next values.
    always_comb begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        value_next  = value_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    value_next = $signed(s_tdata[VALUE_W-1:0]);
                    found_next = 1'b0;
                    if (cmd_t'(s_tuser) == CMD_REMOVE) begin
                        idx_next = '0;
                    end else begin
                        idx_next = count_reg;
                        if (count_reg == CNT_W'(DEPTH)) begin
                            status_next = ST_FULL;
                        end
                    end
                end
            end
            S_INS_RD: begin
                if (idx_reg == '0) begin
                    count_next  = count_reg + CNT_W'(1);
                    status_next = ST_DONE;
                end
            end
            S_INS_CMP: begin
                if (rd_greater) begin
                    idx_next = idx_dec;
                end else begin
                    count_next  = count_reg + CNT_W'(1);
                    status_next = ST_DONE;
                end
            end
            S_REM_RD: begin
                if (idx_reg == count_reg) begin
                    if (found_reg) begin
                        count_next  = count_reg - CNT_W'(1);
                        status_next = ST_DONE;
                    end else begin
                        status_next = ST_MISSING;
                    end
                end
            end
            S_REM_CMP: begin
                idx_next = idx_reg + CNT_W'(1);
                if (rd_equal) begin
                    found_next = 1'b1;
                end
            end
            default: count_next = count_reg;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers; the head copy follows every write to the first entry.
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        if (ram_we && ram_waddr == '0) begin
            head_reg <= $signed(ram_wdata);
        end
        if (out_load) begin
            m_tdata_reg <= {1'b0, smallest, TOTAL_W'(count_reg), status_reg};
        end
    end

    assign smallest = (count_reg == '0) ? '0 : head_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // The entry count never exceeds the store size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above DEPTH");

    // Writes stay within the held entries plus the one slot being filled.
    a_write_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ({1'b0, ram_waddr} <= (IDX_W + 1)'(count_reg)))
        else $error("RAM write beyond the held entries");

    // After an input transfer the unit is not ready in the cycle that follows.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready)
        else $error("input ready right after a transfer");

    // A dropped insert is reported only when the store is full.
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && status_reg == ST_FULL) |-> (count_reg == CNT_W'(DEPTH)))
        else $error("full status with free entries");
`endif

endmodule

// ===== dv/sorted_list_insert_remove_unit_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted list insert and remove checker
// Watches both stream channels of the sorted list unit. Each input transfer is
// applied to a local copy of the sorted store, and the outcome is queued. Each
// result transfer is compared field by field with the oldest queued outcome.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_unit_checker #(
    parameter int DEPTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input channel, observed only.
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [sli_pkg::S_DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic                         s_tuser,   // [0] cmd
    // Result channel, observed only.
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [sli_pkg::M_DATA_W-1:0] m_tdata,   // [1:0] status, [6:2] entry_total,
                                                    // [38:7] smallest, [39] zero
    // Totals handed to the testbench top.
    output int                           mismatch_count,
    output int                           pending,
    output int                           result_count,
    output int                           full_count,
    output int                           missing_count
);
    import sli_pkg::*;

    localparam int TOTAL_LSB = STATUS_W;
    localparam int SMALL_LSB = STATUS_W + TOTAL_W;
    localparam int PAD_LSB   = SMALL_LSB + VALUE_W;

    // One expected result transfer.
    typedef struct packed {
        status_t                    status;
        logic [TOTAL_W-1:0]         total;
        logic signed [VALUE_W-1:0]  smallest;
    } outcome_t;

    outcome_t                  outcome_q[$];
    logic signed [VALUE_W-1:0] held [DEPTH];
    int                        held_count;

    // Place the value after every equal entry, unless the list is full.
    task automatic insert_value(input logic signed [VALUE_W-1:0] v, output status_t st);
        int pos;
        int i;
        pos = 0;
        if (held_count >= DEPTH) begin
            st = ST_FULL;
        end else begin
            while (pos < held_count && held[pos] <= v) pos++;
            for (i = held_count; i > pos; i--) held[i] = held[i-1];
            held[pos] = v;
            held_count++;
            st = ST_DONE;
        end
    endtask

    // Drop the first entry equal to the value, if there is one.
    task automatic remove_value(input logic signed [VALUE_W-1:0] v, output status_t st);
        int pos;
        int i;
        pos = 0;
        while (pos < held_count && held[pos] != v) pos++;
        if (pos >= held_count) begin
            st = ST_MISSING;
        end else begin
            for (i = pos; i + 1 < held_count; i++) held[i] = held[i+1];
            held_count--;
            st = ST_DONE;
        end
    endtask

    // Apply one command to the local store and queue what it must return.
    task automatic predict_command(input cmd_t cmd, input logic signed [VALUE_W-1:0] v);
        outcome_t want;
        status_t  st;
        if (cmd == CMD_INSERT) insert_value(v, st);
        else remove_value(v, st);
        want.status   = st;
        want.total    = TOTAL_W'(held_count);
        want.smallest = (held_count > 0) ? held[0] : '0;
        outcome_q.push_back(want);
    endtask

    // Compare one result transfer with the oldest queued outcome.
    task automatic check_result(input logic [M_DATA_W-1:0] word);
        outcome_t want;
        result_count++;
        if (outcome_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("[%0t] result transfer with no command outstanding: tdata=%h",
                         $time, word);
        end else begin
            want = outcome_q.pop_front();
            if (want.status == ST_FULL) full_count++;
            if (want.status == ST_MISSING) missing_count++;
            if (word[STATUS_W-1:0] !== want.status ||
                word[TOTAL_LSB +: TOTAL_W] !== want.total ||
                word[SMALL_LSB +: VALUE_W] !== want.smallest ||
                word[M_DATA_W-1:PAD_LSB] !== '0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $write("[%0t] result %0d: expected status %0d total %0d smallest %0d,",
                           $time, result_count, want.status, want.total, want.smallest);
                    $display(" got status %0d total %0d smallest %0d pad %b",
                             word[STATUS_W-1:0], word[TOTAL_LSB +: TOTAL_W],
                             $signed(word[SMALL_LSB +: VALUE_W]),
                             word[M_DATA_W-1:PAD_LSB]);
                end
            end
        end
    endtask

    // Sample both channels at each rising edge; results leave before new commands enter.
    always @(posedge aclk) begin
        if (!aresetn) begin
            held_count = 0;
            outcome_q.delete();
        end else begin
            if (m_tvalid && m_tready) check_result(m_tdata);
            if (s_tvalid && s_tready)
                predict_command(cmd_t'(s_tuser), $signed(s_tdata[VALUE_W-1:0]));
        end
        pending = outcome_q.size();
    end

endmodule

// ===== dv/sorted_list_insert_remove_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Sorted list insert and remove testbench
// Drives insert and remove commands into the sorted list unit: a directed
// opening over the value extremes, duplicates, absent values, the empty and
// the full list, then random commands that swing the list between empty and
// full. Both sides idle at random, and the receiver once holds off long
// enough to back the unit up. A separate checker predicts every result.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_unit_tb;
    import sli_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1125;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    int mismatch_count;
    int pending;
    int result_count;
    int full_count;
    int missing_count;
    int sent_count     = 0;
    int directed_count = 0;
    int cycle_count    = 0;
    logic hold_off     = 1'b0;

    logic [VALUE_W-1:0] hot_values [8];

    sorted_list_insert_remove_unit #(
        .DEPTH(DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    sorted_list_insert_remove_unit_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatch_count(mismatch_count),
        .pending       (pending),
        .result_count  (result_count),
        .full_count    (full_count),
        .missing_count (missing_count)
    );

    // Clock generation.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Offer one command, after a random gap unless no_gap is set, and wait for its transfer.
    task automatic send_command(input cmd_t cmd, input logic [VALUE_W-1:0] value,
                                input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    // Refill the set of values that random commands mostly reuse, so removes hit.
    task automatic refresh_hot_values();
        int k;
        for (k = 0; k < 8; k++)
            hot_values[k] = $urandom_range(0, 1) ? $urandom()
                                                 : 32'($urandom_range(0, 7)) - 32'd4;
    endtask

    // Mostly reused values, some fully random ones and some extremes.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return hot_values[$urandom_range(0, 7)];
        endcase
    endfunction

    // Receiver: random stalls between results, bursts without stalls, and the hold-off.
    initial begin
        int stall_left;
        int taken;
        stall_left = 0;
        taken      = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                taken++;
                stall_left = (((taken / 60) % 4) == 2) ? 0 : $urandom_range(0, 8);
            end
            if (!aresetn || hold_off) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering commands.
    initial begin
        wait (sent_count >= HOLD_AFTER);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Watchdog on the cycle count.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus and verdict.
    initial begin
        int   n;
        int   k;
        int   insert_pct;
        cmd_t cmd;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening: empty list, extremes, duplicates, absent values.
        send_command(CMD_REMOVE, 32'h0000_0000, 1'b0);
        send_command(CMD_INSERT, 32'h7FFF_FFFF, 1'b0);
        send_command(CMD_INSERT, 32'h8000_0000, 1'b0);
        send_command(CMD_INSERT, 32'h0000_0000, 1'b0);
        send_command(CMD_INSERT, 32'hFFFF_FFFF, 1'b0);
        send_command(CMD_INSERT, 32'h0000_0000, 1'b0);
        send_command(CMD_REMOVE, 32'h0000_0005, 1'b0);
        send_command(CMD_REMOVE, 32'h8000_0000, 1'b0);
        send_command(CMD_REMOVE, 32'h7FFF_FFFF, 1'b0);

        // Fill the list with a mix of zeros and wide bit patterns.
        for (k = 0; k < 13; k++)
            send_command(CMD_INSERT, (k % 3 == 0) ? 32'h0 : 32'h1357_9BDF * (k + 1), 1'b0);

        // Full list: dropped insert, first-equal remove, new smallest.
        send_command(CMD_INSERT, 32'h0000_0001, 1'b0);
        send_command(CMD_REMOVE, 32'h0000_0000, 1'b0);
        send_command(CMD_INSERT, 32'h8000_0000, 1'b0);
        directed_count = sent_count;

        // Random part: alternating fill and drain phases over reused values.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 128 == 0) refresh_hot_values();
            insert_pct = (((n / 96) % 2) == 0) ? 75 : 30;
            cmd = ($urandom_range(1, 100) <= insert_pct) ? CMD_INSERT : CMD_REMOVE;
            send_command(cmd, pick_value(), ((n / 50) % 5) == 1);
        end
        s_tvalid <= 1'b0;

        // Let the last results come out.
        @(posedge aclk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d commands (%0d directed) and checked %0d results, %0d mismatched.",
                 sent_count, directed_count, result_count, mismatch_count);
        $display("Inserts dropped on a full list: %0d, removes of absent values: %0d.",
                 full_count, missing_count);
        if (mismatch_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
